// ----- rtl/core/ffba_pkg.sv -----
// ============================================================================
// ffba_pkg: shared types and constants of the first-fit block allocator
// Table sizing, status and operation codes, the packed transfer payloads and the table entry.
// ============================================================================
`default_nettype none

package ffba_pkg;

   localparam int MAX_BLOCKS      = 16;
   localparam int IDX_W           = $clog2(MAX_BLOCKS);
   localparam int CNT_W           = $clog2(MAX_BLOCKS + 1);
   localparam int ARENA_BYTES_MAX = 65536;
   localparam int OFF_W           = 16;
   localparam int SIZE_W          = 17;
   localparam int ENTRY_W         = OFF_W + SIZE_W;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NO_SPACE  = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic              op;
      logic [SIZE_W-1:0] alloc_size;
      logic [OFF_W-1:0]  free_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [OFF_W-1:0] offset;
   } rsp_type;

   typedef struct packed {
      logic [OFF_W-1:0]  start;
      logic [SIZE_W-1:0] length;
   } entry_type;

endpackage

`default_nettype wire

// ----- rtl/core/ffba_ram.sv -----
// ============================================================================
// ffba_ram: generic single-write, single-read RAM
// One write port and one read port with the read data registered.
// ============================================================================
`default_nettype none

module ffba_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/core/first_fit_block_allocator.sv -----
// ============================================================================
// first_fit_block_allocator: first-fit allocator over a configurable arena
// Keeps a sorted table of allocated blocks in a RAM and serves allocate and
// free requests one at a time.
// ============================================================================
//
//  channel  direction  payload                  handshake
//  -------  ---------  -----------------------  ---------------------
//  req      in         ffba_pkg::req_type       req_valid / req_ready
//  rsp      out        ffba_pkg::rsp_type       rsp_valid / rsp_ready
//  csr      in         arena_size               csr_valid / csr_ready
//
// One request is worked on at a time; visiting an entry takes a RAM read, then
// a compare, and moving one on an insert or a removal takes a read and a write.
// Synchronous reset clears the state, the entry count and the response valid,
// and sets the arena size to the largest arena; the RAM is never cleared. A
// stalled result waits in an output register, so the next request can already
// start.
`default_nettype none

module first_fit_block_allocator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ffba_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ffba_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [ffba_pkg::SIZE_W-1:0] csr_data
);

   localparam int SW = ffba_pkg::SIZE_W;
   localparam int OW = ffba_pkg::OFF_W;
   localparam int IW = ffba_pkg::IDX_W;
   localparam int CW = ffba_pkg::CNT_W;
   // Running end of the previous block can reach an offset plus a length.
   localparam int PW = SW + 1;
   localparam int SUMW = PW + 1;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN_RD  = 3'd1;
   localparam logic [2:0] S_SCAN_EV  = 3'd2;
   localparam logic [2:0] S_SHIFT_RD = 3'd3;
   localparam logic [2:0] S_SHIFT_WR = 3'd4;
   localparam logic [2:0] S_PLACE    = 3'd5;
   localparam logic [2:0] S_FIN      = 3'd6;

   localparam logic [CW-1:0] CNT_MAX = CW'(ffba_pkg::MAX_BLOCKS);
   localparam logic [SW-1:0] ARENA_MAX = SW'(ffba_pkg::ARENA_BYTES_MAX);

   logic [2:0]   state_ff, state_in;
   logic         op_ff, op_in;
   logic [SW-1:0] size_ff, size_in;
   logic [OW-1:0] foff_ff, foff_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [PW-1:0] prev_ff, prev_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] arena_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   ffba_pkg::rsp_type rsp_ff, rsp_in, res_ff, res_in;

   logic                       ram_we;
   logic [IW-1:0]              ram_waddr, ram_raddr;
   ffba_pkg::entry_type        ram_wdata, ram_rdata;
   logic [SW-1:0]              arena_lim;
   logic [SUMW-1:0]            fit_end;
   logic [CW-1:0]              idx_m1, idx_p1;

   ffba_ram #(
      .WIDTH (ffba_pkg::ENTRY_W),
      .DEPTH (ffba_pkg::MAX_BLOCKS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Values above the largest arena are clipped to it.
   assign arena_lim = (arena_ff > ARENA_MAX) ? ARENA_MAX : arena_ff;
   // A request fits a gap when the previous end plus its size stays within it.
   assign fit_end   = SUMW'(prev_ff) + SUMW'(size_ff);
   assign idx_m1    = idx_ff - CW'(1);
   assign idx_p1    = idx_ff + CW'(1);

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      size_in      = size_ff;
      foff_in      = foff_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      prev_in      = prev_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[IW-1:0];
      ram_wdata    = ram_rdata;
      ram_raddr    = idx_ff[IW-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_data.op;
               size_in = req_data.alloc_size;
               foff_in = req_data.free_offset;
               idx_in  = '0;
               prev_in = '0;
               res_in  = '{status: ffba_pkg::ST_DONE, offset: '0};
               if (req_data.op == ffba_pkg::OP_ALLOC && cnt_ff == CNT_MAX) begin
                  res_in.status = ffba_pkg::ST_FULL;
                  state_in      = S_FIN;
               end else if (req_data.op == ffba_pkg::OP_ALLOC &&
                            req_data.alloc_size == '0) begin
                  res_in.status = ffba_pkg::ST_NO_SPACE;
                  state_in      = S_FIN;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            if (idx_ff == cnt_ff) begin
               // Past the last entry: only the tail gap is left.
               if (op_ff == ffba_pkg::OP_ALLOC) begin
                  if (fit_end <= SUMW'(arena_lim)) begin
                     pos_in        = idx_ff[IW-1:0];
                     res_in.offset = prev_ff[OW-1:0];
                     state_in      = S_PLACE;
                  end else begin
                     res_in.status = ffba_pkg::ST_NO_SPACE;
                     state_in      = S_FIN;
                  end
               end else begin
                  res_in.status = ffba_pkg::ST_NOT_FOUND;
                  state_in      = S_FIN;
               end
            end else begin
               state_in = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            if (op_ff == ffba_pkg::OP_ALLOC) begin
               if (fit_end <= SUMW'(ram_rdata.start)) begin
                  pos_in        = idx_ff[IW-1:0];
                  idx_in        = cnt_ff;
                  res_in.offset = prev_ff[OW-1:0];
                  state_in      = S_SHIFT_RD;
               end else begin
                  prev_in  = PW'(ram_rdata.start) + PW'(ram_rdata.length);
                  idx_in   = idx_p1;
                  state_in = S_SCAN_RD;
               end
            end else begin
               if (ram_rdata.start == foff_ff) begin
                  pos_in   = idx_ff[IW-1:0];
                  state_in = S_SHIFT_RD;
               end else begin
                  idx_in   = idx_p1;
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SHIFT_RD: begin
            if (op_ff == ffba_pkg::OP_ALLOC) begin
               // Open a hole at pos by moving entries up, top first.
               if (idx_ff > CW'(pos_ff)) begin
                  ram_raddr = idx_m1[IW-1:0];
                  state_in  = S_SHIFT_WR;
               end else begin
                  state_in = S_PLACE;
               end
            end else begin
               // Close the hole at pos by moving entries down.
               if (idx_p1 < cnt_ff) begin
                  ram_raddr = idx_p1[IW-1:0];
                  state_in  = S_SHIFT_WR;
               end else begin
                  cnt_in   = cnt_ff - CW'(1);
                  state_in = S_FIN;
               end
            end
         end
         S_SHIFT_WR: begin
            ram_we   = 1'b1;
            idx_in   = (op_ff == ffba_pkg::OP_ALLOC) ? idx_m1 : idx_p1;
            state_in = S_SHIFT_RD;
         end
         S_PLACE: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = '{start: prev_ff[OW-1:0], length: size_ff};
            cnt_in    = cnt_ff + CW'(1);
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         arena_ff     <= ARENA_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            arena_ff <= csr_data;
         end
      end
      op_ff   <= op_in;
      size_ff <= size_in;
      foff_ff <= foff_in;
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      prev_ff <= prev_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire
